// ===== hw/rtl/fsr_pkg.sv =====
// Shared types, constants and reset image for the fuse register file.
package fsr_pkg;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,
        OP_SET    = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_TOGGLE = 2'd3
    } t_wr_op;

    localparam int unsigned ADDR_W  = 10;
    localparam int unsigned DATA_W  = 32;

    localparam logic [ADDR_W-1:0] CTRL_WORD         = 10'h000;
    localparam logic [ADDR_W-1:0] RELOAD_GROUP_WORD = 10'h018;
    localparam logic [ADDR_W-1:0] SHADOW_BASE_WORD  = 10'h01C;
    localparam logic [ADDR_W-1:0] BANK_BASE_WORD    = 10'h100;
    localparam logic [DATA_W-1:0] CTRL_CLEAR_MASK   = 32'h0000_0700;

    localparam logic [DATA_W-1:0] KEY_WORDS [8] = '{
        32'h7728d930, 32'h840fe74c, 32'h6b402fbb, 32'h1112612a,
        32'ha99305de, 32'h40017071, 32'h26e8623f, 32'he34e6f12
    };

    // Power-on image of the store, one word per address.
    function automatic logic [DATA_W-1:0] fsr_reset_word(input logic [ADDR_W-1:0] idx);
        logic [DATA_W-1:0] w;
        w = '0;
        if (idx == 10'h050) begin
            w = 32'h0001_0000;
        end else if (idx == 10'h100) begin
            w = 32'h0000_0200;  // fuse lock
        end else if (idx == 10'h11C) begin
            w = 32'h0200_0000;  // closed configuration
        end else if (idx[9:5] == 5'h0B && idx[1:0] == 2'b00) begin
            w = KEY_WORDS[idx[4:2]];
        end
        return w;
    endfunction

endpackage

// ===== hw/rtl/fsr_ram.sv =====
// Generic single-port RAM with registered read data.
module fsr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fuse_register_file_with_shadow_reload.sv =====
// Fuse register file: set/clear/toggle write aliases and shadow reload.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+----------------------------------
//  s       | in  | i_s_tvalid / o_s_tready    | tuser: cmd; tdata: word_addr, data
//  m       | out | o_m_tvalid / i_m_tready    | tdata: read_data
//
// A read runs S_RD, S_RDCAP, S_FIN; a write runs S_CTRL_RD, S_BASE_RD, S_BASE_WR,
// an S_SH_RD/S_SH_WR pair per shadow word on a reload, S_CTRL_WR and S_FIN, all
// through the single memory port. After reset a clearing pass loads the reset
// image, with o_s_tready low. A request is taken while the previous result waits;
// the sequencer holds in its final state until the output register is free.
module fuse_register_file_with_shadow_reload #(
    parameter int unsigned STORE_WORDS  = 1024,
    parameter int unsigned SHADOW_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [9:0] word_addr, [41:10] write_data, rest zero
    input  logic        i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [31:0] read_data
);
    import fsr_pkg::*;

    localparam int unsigned AW = $clog2(STORE_WORDS);
    localparam logic [ADDR_W:0] LIMIT = (ADDR_W+1)'(STORE_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);
    localparam logic [1:0] LAST_SHADOW = 2'(SHADOW_COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_RDCAP, S_CTRL_RD, S_BASE_RD, S_BASE_WR,
        S_SH_RD, S_SH_WR, S_CTRL_WR, S_FIN
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr_idx;
    logic [1:0]         r_idx;
    logic               r_cmd;
    logic [ADDR_W-1:0]  r_addr;
    logic [DATA_W-1:0]  r_data;
    logic               r_in_range;
    logic [DATA_W-1:0]  r_ctrl;
    logic [3:0]         r_bank;
    logic [DATA_W-1:0]  r_res;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_data;

    logic               mem_en;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [DATA_W-1:0]  mem_rdata;

    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic [DATA_W-1:0]  n_word;
    logic               reload;
    logic               out_free;
    logic               in_take;

    assign base_addr = {r_addr[ADDR_W-1:2], 2'b00};
    assign src_addr  = BANK_BASE_WORD + {2'b00, r_bank, 4'b0000} + {6'd0, r_idx, 2'b00};
    assign dst_addr  = SHADOW_BASE_WORD + {6'd0, r_idx, 2'b00};
    assign reload    = (base_addr == RELOAD_GROUP_WORD) && r_data[0];
    assign out_free  = !r_out_valid || i_m_tready;
    assign in_take   = i_s_tvalid && o_s_tready;

    always_comb begin
        case (t_wr_op'(r_addr[1:0]))
            OP_STORE:  n_word = r_data;
            OP_SET:    n_word = mem_rdata | r_data;
            OP_CLEAR:  n_word = mem_rdata & ~r_data;
            OP_TOGGLE: n_word = mem_rdata ^ r_data;
            default:   n_word = r_data;
        endcase
    end

    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_clr_idx;
                mem_wdata = fsr_reset_word(ADDR_W'(r_clr_idx));
            end
            S_RD: begin
                mem_en   = r_in_range;
                mem_addr = r_addr[AW-1:0];
            end
            S_CTRL_RD: begin
                mem_en   = 1'b1;
                mem_addr = CTRL_WORD[AW-1:0];
            end
            S_BASE_RD: begin
                mem_en   = r_in_range;
                mem_addr = base_addr[AW-1:0];
            end
            S_BASE_WR: begin
                mem_en    = r_in_range;
                mem_we    = r_in_range;
                mem_addr  = base_addr[AW-1:0];
                mem_wdata = n_word;
            end
            S_SH_RD: begin
                mem_en   = 1'b1;
                mem_addr = src_addr[AW-1:0];
            end
            S_SH_WR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = dst_addr[AW-1:0];
                mem_wdata = mem_rdata;
            end
            S_CTRL_WR: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = CTRL_WORD[AW-1:0];
                mem_wdata = r_ctrl & ~CTRL_CLEAR_MASK;
            end
            default: begin
            end
        endcase
    end

    fsr_ram #(
        .WIDTH(DATA_W),
        .DEPTH(STORE_WORDS)
    ) u_store (
        .i_clk  (i_clk),
        .i_en   (mem_en),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_FIN the output register is handled by the state itself
            if (r_out_valid && i_m_tready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_take) begin
                        r_cmd      <= i_s_tuser;
                        r_addr     <= i_s_tdata[9:0];
                        r_data     <= i_s_tdata[41:10];
                        r_in_range <= ({1'b0, i_s_tdata[9:0]} < LIMIT);
                        r_state    <= (t_cmd'(i_s_tuser) == CMD_READ) ? S_RD : S_CTRL_RD;
                    end
                end
                S_RD:      r_state <= S_RDCAP;
                S_RDCAP: begin
                    r_res   <= r_in_range ? mem_rdata : '0;
                    r_state <= S_FIN;
                end
                S_CTRL_RD: r_state <= S_BASE_RD;
                S_BASE_RD: begin
                    r_ctrl  <= mem_rdata;
                    r_bank  <= mem_rdata[3:0];  // bank from control word before this write
                    r_state <= S_BASE_WR;
                end
                S_BASE_WR: begin
                    if (base_addr == CTRL_WORD) begin
                        r_ctrl <= n_word;
                    end
                    r_idx   <= '0;
                    r_state <= reload ? S_SH_RD : S_CTRL_WR;
                end
                S_SH_RD:   r_state <= S_SH_WR;
                S_SH_WR: begin
                    r_idx <= r_idx + 1'b1;
                    r_state <= (r_idx == LAST_SHADOW) ? S_CTRL_WR : S_SH_RD;
                end
                S_CTRL_WR: begin
                    r_res   <= '0;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A finished result waits while the output register is still full.
    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_m_tready) |=> (r_state == S_FIN))
        else $error("result lost while output register full");

    a_ctrl_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CTRL_WR) |->
            (mem_we && mem_addr == '0 && (mem_wdata & CTRL_CLEAR_MASK) == '0))
        else $error("control write does not clear bits 8 to 10");

    a_reload_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_RD) |-> (r_cmd && reload))
        else $error("shadow copy without a reload request");

    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("request taken during clearing pass");

endmodule
